/* sv/jcs_pkg.sv */
// Shared constants and the result word type for the JTAG command shifter.
package jcs_pkg;

  localparam int MAX_BYTES = 512;
  localparam int ADDR_W    = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int CNT_W     = $clog2(MAX_BYTES + 1);
  localparam int BIT_W     = $clog2(MAX_BYTES * 8);
  localparam int TOT_W     = BIT_W + 1;

  localparam logic [7:0] OP_BOOT     = 8'h00;
  localparam logic [7:0] OP_ACK_A    = 8'h20;
  localparam logic [7:0] OP_ACK_B    = 8'h21;
  localparam logic [7:0] OP_TMS_ONLY = 8'h22;
  localparam logic [7:0] OP_TMS_TDI  = 8'h23;
  localparam logic [7:0] ACK_BYTE    = 8'h06;

  localparam logic REQ_HOST = 1'b0;
  localparam logic REQ_BIT  = 1'b1;

  typedef struct packed {
    logic       drive_valid;
    logic       tms_level;
    logic       tdi_level;
    logic       seq_end;
    logic       reply_valid;
    logic [7:0] reply_byte;
    logic       enter_boot;
  } result_t;

endpackage

/* sv/jtag_command_shifter.sv */
// Top level: command parser, TMS/TDI byte stores and the bit shift engine.
//
// One input word is taken per clock while in_stall is low: a host byte
// (req_type 0) or a bit-done report with its sampled TDO (req_type 1). A
// result goes to the output register, or to the second buffer entry while
// the output is held. TMS and TDI bytes live in two 512x8 synchronous RAMs;
// the byte after the shifted one is read ahead, so unstalled bit-done words
// may follow every cycle with no gap at byte boundaries. A two-entry output
// buffer keeps accepting words while one result waits; in_stall rises only
// when both entries are full. No clearing pass is needed after reset.
module jtag_command_shifter
  import jcs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_req_type,
  input  logic [7:0] in_host_byte,
  input  logic       in_tdo_level,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_drive_valid,
  output logic       out_tms_level,
  output logic       out_tdi_level,
  output logic       out_seq_end,
  output logic       out_reply_valid,
  output logic [7:0] out_reply_byte,
  output logic       out_enter_boot
);

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_LEN_LO = 3'd1;
  localparam logic [2:0] PH_LEN_HI = 3'd2;
  localparam logic [2:0] PH_TMS    = 3'd3;
  localparam logic [2:0] PH_TDI    = 3'd4;
  localparam logic [2:0] PH_SHIFT  = 3'd5;

  logic [2:0]       phase_r, phase_nxt;
  logic             capture_r, capture_nxt;
  logic [TOT_W-1:0] bit_total_r, bit_total_nxt;
  logic [7:0]       len_lo_r, len_lo_nxt;
  logic [CNT_W-1:0] need_r, need_nxt;
  logic [CNT_W-1:0] byte_idx_r, byte_idx_nxt;
  logic [BIT_W-1:0] bit_idx_r, bit_idx_nxt;
  logic [7:0]       tdo_pack_r, tdo_pack_nxt;
  logic [7:0]       cur_tms_r, cur_tms_nxt;
  logic [7:0]       cur_tdi_r, cur_tdi_nxt;

  logic [7:0]       tms_mem [MAX_BYTES];
  logic [7:0]       tdi_mem [MAX_BYTES];
  logic [7:0]       tms_rdata_r;
  logic [7:0]       tdi_rdata_r;
  logic             tms_we;
  logic             tdi_we;
  logic             rd_en;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;

  logic             in_acc;
  logic             has_res;
  result_t          res;
  result_t          out_word;

  logic [TOT_W-1:0] bit_next_w;
  logic [BIT_W-1:0] bit_next;
  logic             last_bit;
  logic [7:0]       pack_w;
  logic [7:0]       tms_byte;
  logic [7:0]       tdi_byte;
  logic [16:0]      len_sum;
  logic [16:0]      need_w;
  logic [CNT_W-1:0] cnt_inc;

  assign in_acc     = in_valid && !in_stall;
  assign waddr      = byte_idx_r[ADDR_W-1:0];
  assign bit_next_w = TOT_W'(bit_idx_r) + TOT_W'(1);
  assign bit_next   = bit_next_w[BIT_W-1:0];
  assign last_bit   = bit_next_w >= bit_total_r;
  assign pack_w     = tdo_pack_r | (8'(in_tdo_level) << bit_idx_r[2:0]);
  assign len_sum    = {1'b0, in_host_byte, len_lo_r} + 17'd7;
  assign need_w     = len_sum >> 3;
  assign cnt_inc    = byte_idx_r + CNT_W'(1);

  always_comb begin
    phase_nxt     = phase_r;
    capture_nxt   = capture_r;
    bit_total_nxt = bit_total_r;
    len_lo_nxt    = len_lo_r;
    need_nxt      = need_r;
    byte_idx_nxt  = byte_idx_r;
    bit_idx_nxt   = bit_idx_r;
    tdo_pack_nxt  = tdo_pack_r;
    cur_tms_nxt   = cur_tms_r;
    cur_tdi_nxt   = cur_tdi_r;
    tms_we        = 1'b0;
    tdi_we        = 1'b0;
    rd_en         = 1'b0;
    raddr         = ADDR_W'(1);
    has_res       = 1'b0;
    res           = '0;
    tms_byte      = cur_tms_r;
    tdi_byte      = cur_tdi_r;

    if (in_req_type == REQ_BIT) begin
      if (phase_r == PH_SHIFT) begin
        has_res = 1'b1;
        if (capture_r) begin
          tdo_pack_nxt = pack_w;
          if (bit_idx_r[2:0] == 3'd7 || last_bit) begin
            res.reply_valid = 1'b1;
            res.reply_byte  = pack_w;
            tdo_pack_nxt    = 8'h00;
          end
        end
        if (last_bit) begin
          res.seq_end = 1'b1;
          phase_nxt   = PH_IDLE;
          if (!capture_r) begin
            res.reply_valid = 1'b1;
            res.reply_byte  = ACK_BYTE;
          end
        end else begin
          bit_idx_nxt = bit_next;
          if (bit_next[2:0] == 3'd0) begin
            // step into the prefetched byte and fetch the one after it
            tms_byte    = tms_rdata_r;
            tdi_byte    = tdi_rdata_r;
            cur_tms_nxt = tms_rdata_r;
            cur_tdi_nxt = tdi_rdata_r;
            rd_en       = 1'b1;
            raddr       = ADDR_W'(bit_next >> 3) + ADDR_W'(1);
          end
          res.drive_valid = 1'b1;
          res.tms_level   = tms_byte[bit_next[2:0]];
          res.tdi_level   = capture_r & tdi_byte[bit_next[2:0]];
        end
      end
    end else begin
      case (phase_r)
        PH_IDLE: begin
          case (in_host_byte)
            OP_TMS_ONLY, OP_TMS_TDI: begin
              capture_nxt = (in_host_byte == OP_TMS_TDI);
              phase_nxt   = PH_LEN_LO;
            end
            OP_ACK_A, OP_ACK_B: begin
              has_res         = 1'b1;
              res.reply_valid = 1'b1;
              res.reply_byte  = ACK_BYTE;
            end
            OP_BOOT: begin
              has_res        = 1'b1;
              res.enter_boot = 1'b1;
            end
            default: begin
            end
          endcase
        end
        PH_LEN_LO: begin
          len_lo_nxt = in_host_byte;
          phase_nxt  = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          if (need_w > 17'(MAX_BYTES)) begin
            phase_nxt = PH_IDLE;
          end else if (in_host_byte == 8'h00 && len_lo_r == 8'h00) begin
            phase_nxt   = PH_IDLE;
            has_res     = 1'b1;
            res.seq_end = 1'b1;
            if (!capture_r) begin
              res.reply_valid = 1'b1;
              res.reply_byte  = ACK_BYTE;
            end
          end else begin
            bit_total_nxt = TOT_W'({in_host_byte, len_lo_r});
            need_nxt      = CNT_W'(need_w);
            byte_idx_nxt  = '0;
            phase_nxt     = PH_TMS;
          end
        end
        PH_TMS: begin
          tms_we = 1'b1;
          if (byte_idx_r == '0) begin
            cur_tms_nxt = in_host_byte;
            tms_byte    = in_host_byte;
          end
          if (cnt_inc >= need_r) begin
            byte_idx_nxt = '0;
            if (capture_r) begin
              phase_nxt = PH_TDI;
            end else begin
              phase_nxt       = PH_SHIFT;
              bit_idx_nxt     = '0;
              tdo_pack_nxt    = 8'h00;
              rd_en           = 1'b1;
              has_res         = 1'b1;
              res.drive_valid = 1'b1;
              res.tms_level   = tms_byte[0];
            end
          end else begin
            byte_idx_nxt = cnt_inc;
          end
        end
        PH_TDI: begin
          tdi_we = 1'b1;
          if (byte_idx_r == '0) begin
            cur_tdi_nxt = in_host_byte;
            tdi_byte    = in_host_byte;
          end
          if (cnt_inc >= need_r) begin
            byte_idx_nxt    = '0;
            phase_nxt       = PH_SHIFT;
            bit_idx_nxt     = '0;
            tdo_pack_nxt    = 8'h00;
            rd_en           = 1'b1;
            has_res         = 1'b1;
            res.drive_valid = 1'b1;
            res.tms_level   = tms_byte[0];
            res.tdi_level   = tdi_byte[0];
          end else begin
            byte_idx_nxt = cnt_inc;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      capture_r   <= 1'b0;
      bit_total_r <= '0;
      len_lo_r    <= 8'h00;
      need_r      <= '0;
      byte_idx_r  <= '0;
      bit_idx_r   <= '0;
      tdo_pack_r  <= 8'h00;
    end else if (in_acc) begin
      phase_r     <= phase_nxt;
      capture_r   <= capture_nxt;
      bit_total_r <= bit_total_nxt;
      len_lo_r    <= len_lo_nxt;
      need_r      <= need_nxt;
      byte_idx_r  <= byte_idx_nxt;
      bit_idx_r   <= bit_idx_nxt;
      tdo_pack_r  <= tdo_pack_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cur_tms_r <= cur_tms_nxt;
      cur_tdi_r <= cur_tdi_nxt;
    end
  end

  // forward the byte being written when the prefetch hits the same entry
  always_ff @(posedge clk) begin
    if (in_acc && tms_we) begin
      tms_mem[waddr] <= in_host_byte;
    end
    if (in_acc && rd_en) begin
      if (tms_we && waddr == raddr) begin
        tms_rdata_r <= in_host_byte;
      end else begin
        tms_rdata_r <= tms_mem[raddr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && tdi_we) begin
      tdi_mem[waddr] <= in_host_byte;
    end
    if (in_acc && rd_en) begin
      if (tdi_we && waddr == raddr) begin
        tdi_rdata_r <= in_host_byte;
      end else begin
        tdi_rdata_r <= tdi_mem[raddr];
      end
    end
  end

  jcs_out_skid u_out_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_acc && has_res),
    .push_data (res),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_word)
  );

  assign out_drive_valid = out_word.drive_valid;
  assign out_tms_level   = out_word.tms_level;
  assign out_tdi_level   = out_word.tdi_level;
  assign out_seq_end     = out_word.seq_end;
  assign out_reply_valid = out_word.reply_valid;
  assign out_reply_byte  = out_word.reply_byte;
  assign out_enter_boot  = out_word.enter_boot;

endmodule

/* sv/jcs_out_skid.sv */
// Two-entry output buffer that parts the result channel from the command logic.
module jcs_out_skid
  import jcs_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_data
);

  logic    out_valid_r;
  logic    skid_valid_r;
  result_t out_data_r;
  result_t skid_data_r;
  logic    out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else begin
        out_data_r <= push_data;
      end
    end else if (push) begin
      skid_data_r <= push_data;
    end
  end

endmodule

/* tb/tb_jtag_command_shifter.sv */
// Self-checking testbench for the JTAG command shifter: random command streams.
module tb_jtag_command_shifter;
  import jcs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD   = 20;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 10;
  localparam int RANDOM_WORDS = 1450;
  localparam int MAX_BITS     = MAX_BYTES * 8;
  localparam int TAIL_BITS    = 256;
  localparam int TAIL_WORDS   = 3 + 2 * (TAIL_BITS / 8) + TAIL_BITS + 1;

  typedef enum logic [2:0] {
    P_IDLE, P_LEN_LO, P_LEN_HI, P_TMS, P_TDI, P_SHIFT
  } parse_phase_t;

  typedef struct {
    logic       req_type;
    logic [7:0] host_byte;
    logic       tdo_level;
  } req_word_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       in_req_type = REQ_HOST;
  logic [7:0] in_host_byte = 8'h00;
  logic       in_tdo_level = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_drive_valid;
  logic       out_tms_level;
  logic       out_tdi_level;
  logic       out_seq_end;
  logic       out_reply_valid;
  logic [7:0] out_reply_byte;
  logic       out_enter_boot;

  req_word_t   req_words[$];
  result_t     due_results[$];
  int unsigned fail_count;
  int unsigned idle_cycles;
  int unsigned in_gap;
  int unsigned out_hold;
  bit          in_fired;
  bit          in_calm;
  bit          out_calm;

  parse_phase_t ph;
  bit           capture;
  int unsigned  total_bits;
  int unsigned  byte_idx;
  int unsigned  bit_idx;
  logic [7:0]   tdo_pack;
  logic [7:0]   tms_bytes[MAX_BYTES];
  logic [7:0]   tdi_bytes[MAX_BYTES];

  jtag_command_shifter dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_host_byte    (in_host_byte),
    .in_tdo_level    (in_tdo_level),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_drive_valid (out_drive_valid),
    .out_tms_level   (out_tms_level),
    .out_tdi_level   (out_tdi_level),
    .out_seq_end     (out_seq_end),
    .out_reply_valid (out_reply_valid),
    .out_reply_byte  (out_reply_byte),
    .out_enter_boot  (out_enter_boot)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic int unsigned gap_len(inout bit calm);
    int unsigned r;
    if ($urandom_range(0, 199) == 0) calm = !calm;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned bytes_needed();
    return (total_bits + 7) >> 3;
  endfunction

  function automatic void drive_bit(inout result_t r, input int unsigned i);
    r.drive_valid = 1'b1;
    r.tms_level   = tms_bytes[i >> 3][i % 8];
    r.tdi_level   = capture ? tdi_bytes[i >> 3][i % 8] : 1'b0;
  endfunction

  task automatic predict_shift_result(input logic rt, input logic [7:0] hb, input logic tdo);
    result_t     r;
    bit          emit;
    int unsigned i;
    r    = '0;
    emit = 1'b0;
    if (rt == REQ_BIT) begin
      if (ph == P_SHIFT) begin
        emit = 1'b1;
        i    = bit_idx;
        if (capture) begin
          tdo_pack[i % 8] = tdo;
          if (i % 8 == 7 || i + 1 >= total_bits) begin
            r.reply_valid = 1'b1;
            r.reply_byte  = tdo_pack;
            tdo_pack      = '0;
          end
        end
        if (i + 1 >= total_bits) begin
          r.seq_end = 1'b1;
          if (!capture) begin
            r.reply_valid = 1'b1;
            r.reply_byte  = ACK_BYTE;
          end
          ph = P_IDLE;
        end else begin
          bit_idx = i + 1;
          drive_bit(r, bit_idx);
        end
      end
    end else begin
      case (ph)
        P_IDLE: begin
          if (hb == OP_TMS_TDI || hb == OP_TMS_ONLY) begin
            capture = (hb == OP_TMS_TDI);
            ph      = P_LEN_LO;
          end else if (hb == OP_ACK_A || hb == OP_ACK_B) begin
            emit          = 1'b1;
            r.reply_valid = 1'b1;
            r.reply_byte  = ACK_BYTE;
          end else if (hb == OP_BOOT) begin
            emit         = 1'b1;
            r.enter_boot = 1'b1;
          end
        end
        P_LEN_LO: begin
          total_bits = 32'(hb);
          ph         = P_LEN_HI;
        end
        P_LEN_HI: begin
          total_bits = 32'({hb, total_bits[7:0]});
          if (bytes_needed() > MAX_BYTES) begin
            ph = P_IDLE;
          end else if (total_bits == 0) begin
            ph        = P_IDLE;
            emit      = 1'b1;
            r.seq_end = 1'b1;
            if (!capture) begin
              r.reply_valid = 1'b1;
              r.reply_byte  = ACK_BYTE;
            end
          end else begin
            byte_idx = 0;
            ph       = P_TMS;
          end
        end
        P_TMS, P_TDI: begin
          if (ph == P_TMS) tms_bytes[byte_idx] = hb;
          else tdi_bytes[byte_idx] = hb;
          byte_idx++;
          if (byte_idx >= bytes_needed()) begin
            byte_idx = 0;
            if (ph == P_TMS && capture) begin
              ph = P_TDI;
            end else begin
              ph       = P_SHIFT;
              bit_idx  = 0;
              tdo_pack = '0;
              emit     = 1'b1;
              drive_bit(r, 0);
            end
          end
        end
        default: begin
        end
      endcase
    end
    if (emit) due_results.push_back(r);
  endtask

  task automatic add_word(input logic rt, input logic [7:0] hb, input logic tdo);
    req_word_t w;
    w.req_type  = rt;
    w.host_byte = hb;
    w.tdo_level = tdo;
    req_words.push_back(w);
  endtask

  task automatic maybe_noise(input logic rt);
    if ($urandom_range(0, 99) < 4) begin
      add_word(rt, 8'($urandom), 1'($urandom));
    end
  endtask

  task automatic add_shift_cmd(input logic [7:0] op, input int unsigned nbits);
    int unsigned nbytes;
    nbytes = (nbits + 7) / 8;
    add_word(REQ_HOST, op, 1'($urandom));
    maybe_noise(REQ_BIT);
    add_word(REQ_HOST, nbits[7:0], 1'($urandom));
    maybe_noise(REQ_BIT);
    add_word(REQ_HOST, nbits[15:8], 1'($urandom));
    if (nbits == 0 || nbytes > MAX_BYTES) return;
    repeat ((op == OP_TMS_TDI) ? 2 * nbytes : nbytes) begin
      maybe_noise(REQ_BIT);
      add_word(REQ_HOST, 8'($urandom), 1'($urandom));
    end
    repeat (nbits) begin
      maybe_noise(REQ_HOST);
      add_word(REQ_BIT, 8'($urandom), 1'($urandom));
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Stimulus, reset and end of run.
  initial begin
    int unsigned r;
    int unsigned nbits;
    logic [7:0]  b;

    add_word(REQ_HOST, OP_BOOT, 1'b0);
    add_word(REQ_HOST, OP_ACK_A, 1'b1);
    add_word(REQ_HOST, OP_ACK_B, 1'b0);
    add_word(REQ_HOST, 8'hFF, 1'b1);
    add_word(REQ_BIT, 8'h00, 1'b1);
    add_shift_cmd(OP_TMS_ONLY, 0);
    add_shift_cmd(OP_TMS_TDI, 0);
    add_shift_cmd(OP_TMS_TDI, MAX_BITS + 1);
    add_shift_cmd(OP_TMS_ONLY, 16'hFFFF);
    add_shift_cmd(OP_TMS_TDI, 3);
    add_word(REQ_HOST, OP_ACK_A, 1'b0);

    while (req_words.size() < RANDOM_WORDS - TAIL_WORDS) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        r = $urandom_range(0, 99);
        if (r < 4) nbits = 0;
        else if (r < 12) nbits = $urandom_range(MAX_BITS + 1, 65535);
        else if (r < 15) nbits = $urandom_range(100, 300);
        else nbits = $urandom_range(1, 40);
        add_shift_cmd($urandom_range(0, 1) ? OP_TMS_TDI : OP_TMS_ONLY, nbits);
      end else if (r < 85) begin
        case ($urandom_range(0, 2))
          0: b = OP_BOOT;
          1: b = OP_ACK_A;
          default: b = OP_ACK_B;
        endcase
        add_word(REQ_HOST, b, 1'($urandom));
      end else begin
        do b = 8'($urandom);
        while (b inside {OP_BOOT, OP_ACK_A, OP_ACK_B, OP_TMS_ONLY, OP_TMS_TDI});
        add_word($urandom_range(0, 1) ? REQ_BIT : REQ_HOST, b, 1'($urandom));
      end
    end
    add_shift_cmd(OP_TMS_TDI, TAIL_BITS);
    add_word(REQ_HOST, OP_ACK_B, 1'b0);

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    do @(posedge clk); while (req_words.size() != 0 || in_valid);
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  always @(negedge clk) begin : driver
    req_word_t w;
    if (rst_n && (in_fired || !in_valid)) begin
      if (in_fired) begin
        in_fired = 1'b0;
        in_gap   = gap_len(in_calm);
      end
      if (in_gap == 0 && req_words.size() != 0) begin
        w = req_words.pop_front();
        in_req_type  <= w.req_type;
        in_host_byte <= w.host_byte;
        in_tdo_level <= w.tdo_level;
        in_valid     <= 1'b1;
      end else begin
        if (in_gap != 0) in_gap--;
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (out_hold != 0) begin
      out_stall <= 1'b1;
      out_hold--;
    end else begin
      out_stall <= 1'b0;
      out_hold = gap_len(out_calm);
    end
  end

  always @(posedge clk) begin : monitor
    result_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        in_fired = 1'b1;
        predict_shift_result(in_req_type, in_host_byte, in_tdo_level);
      end
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual drv=%b tms=%b tdi=%b",
                   $time, out_drive_valid, out_tms_level, out_tdi_level);
          $display("%0t:   end=%b rpl=%b byte=%0h boot=%b",
                   $time, out_seq_end, out_reply_valid, out_reply_byte, out_enter_boot);
          fail_count++;
        end else begin
          want = due_results.pop_front();
          check_field("drive_valid", 8'(want.drive_valid), 8'(out_drive_valid));
          check_field("tms_level", 8'(want.tms_level), 8'(out_tms_level));
          check_field("tdi_level", 8'(want.tdi_level), 8'(out_tdi_level));
          check_field("seq_end", 8'(want.seq_end), 8'(out_seq_end));
          check_field("reply_valid", 8'(want.reply_valid), 8'(out_reply_valid));
          check_field("reply_byte", want.reply_byte, out_reply_byte);
          check_field("enter_boot", 8'(want.enter_boot), 8'(out_enter_boot));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no word moved for %0d cycles, %0d results still due",
                 $time, idle_cycles, due_results.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

endmodule
